// File: rtl/core/wpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wpt_pkg;

  // Default sizes of the table.
  localparam int ENTRIES_DEF     = 8;
  localparam int TOKEN_BITS_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 3;

  // Action codes of an input transaction.
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] STAT_RAISED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_WRITTEN  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP,
    ST_FINISH
  } wpt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic swap_step;
    logic load_out;
  } wpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic swap_last;
  } wpt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/wpt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wpt_in_if #(
  parameter int TOKEN_BITS  = 16,
  parameter int WEIGHT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [TOKEN_BITS-1:0]  token;
  logic [2:0]             slot;
  logic [WEIGHT_BITS-1:0] entry_weight;
  logic                   entry_valid;

  modport source (
    output valid, action, token, slot, entry_weight, entry_valid,
    input  ready
  );

  modport sink (
    input  valid, action, token, slot, entry_weight, entry_valid,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/wpt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wpt_out_if #(
  parameter int TOKEN_BITS  = 16,
  parameter int WEIGHT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [TOKEN_BITS-1:0]  out_token;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic                   out_valid;

  modport source (
    output valid, status, out_token, out_weight, out_valid,
    input  ready
  );

  modport sink (
    input  valid, status, out_token, out_weight, out_valid,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/weighted_prediction_table.sv
// Weighted prediction table: ENTRIES slots, each with a token, a weight and a
// valid mark. Input transactions arrive on in_ch_i and carry an action: add a
// token, write a slot, read a slot, or clear the table. Each input transaction
// yields exactly one result transaction on out_ch_o with a status and the
// contents of the reported slot (slot zero after an add).
// An add runs a parallel match and insert in the execute state, then a
// front-to-back neighbor swap pass over the ENTRIES-1 neighbor pairs, one pair
// per cycle on the pass counter. The result is loaded in the finish state after
// the pass, and a new input is taken once the controller is back in idle. Write,
// read and clear skip the pass and go from execute straight to finish.
// The block takes one item at a time; in_ch_i.ready is high while the
// controller is idle. The output register holds the result while the receiver
// stalls, and the next input is accepted meanwhile; the following result
// waits in the finish state until the output register is drained.
// Reset clears the table to all zero, empty, and leaves no result pending.
`timescale 1ns / 1ps
`default_nettype none

module weighted_prediction_table #(
  parameter int ENTRIES     = wpt_pkg::ENTRIES_DEF,
  parameter int TOKEN_BITS  = wpt_pkg::TOKEN_BITS_DEF,
  parameter int WEIGHT_BITS = wpt_pkg::WEIGHT_BITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  wpt_in_if.sink   in_ch_i,
  wpt_out_if.source out_ch_o
);
  import wpt_pkg::*;

  wpt_cmd_t  cmd;
  wpt_stat_t stat;

  wpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wpt_datapath #(
    .ENTRIES     (ENTRIES),
    .TOKEN_BITS  (TOKEN_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (in_ch_i.action),
    .token_i        (in_ch_i.token),
    .slot_i         (in_ch_i.slot),
    .entry_weight_i (in_ch_i.entry_weight),
    .entry_valid_i  (in_ch_i.entry_valid),
    .status_o       (out_ch_o.status),
    .out_token_o    (out_ch_o.out_token),
    .out_weight_o   (out_ch_o.out_weight),
    .out_valid_o    (out_ch_o.out_valid)
  );

  // Only one item is in flight: no input is taken right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> !in_ch_i.ready)
    else $error("input accepted while an item is in flight");

  // A result load always presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_ch_o.valid)
    else $error("result load did not raise the output valid");

  // A result is never loaded while an earlier one is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_ch_o.valid || out_ch_o.ready))
    else $error("result overwritten while the receiver stalls");

  // A clear reports an empty slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && (out_ch_o.status == STAT_CLEARED)) |->
      ((out_ch_o.out_token == '0) && (out_ch_o.out_weight == '0) && !out_ch_o.out_valid))
    else $error("clear result carries nonzero contents");

endmodule

`default_nettype wire

// File: rtl/core/wpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wpt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire wpt_pkg::wpt_stat_t stat_i,
  output wpt_pkg::wpt_cmd_t     cmd_o
);
  import wpt_pkg::*;

  wpt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.is_add ? ST_SWAP : ST_FINISH;
      end
      ST_SWAP: begin
        if (stat_i.swap_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and the input handshake.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_SWAP: begin
        cmd_o.swap_step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output valid flag follows loads and completed result transactions.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wpt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wpt_datapath #(
  parameter int ENTRIES     = wpt_pkg::ENTRIES_DEF,
  parameter int TOKEN_BITS  = wpt_pkg::TOKEN_BITS_DEF,
  parameter int WEIGHT_BITS = wpt_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wpt_pkg::wpt_cmd_t             cmd_i,
  output wpt_pkg::wpt_stat_t                 stat_o,
  input  wire logic [wpt_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [TOKEN_BITS-1:0]         token_i,
  input  wire logic [wpt_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic [WEIGHT_BITS-1:0]        entry_weight_i,
  input  wire logic                          entry_valid_i,
  output logic [wpt_pkg::STATUS_W-1:0]       status_o,
  output logic [TOKEN_BITS-1:0]              out_token_o,
  output logic [WEIGHT_BITS-1:0]             out_weight_o,
  output logic                               out_valid_o
);
  import wpt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // Captured input transaction.
  logic [ACTION_W-1:0]    act_q;
  logic [TOKEN_BITS-1:0]  tok_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [WEIGHT_BITS-1:0] wgt_q;
  logic                   vld_q;

  // Table contents.
  logic [TOKEN_BITS-1:0]  tab_tok_q [ENTRIES];
  logic [TOKEN_BITS-1:0]  tab_tok_d [ENTRIES];
  logic [WEIGHT_BITS-1:0] tab_wt_q  [ENTRIES];
  logic [WEIGHT_BITS-1:0] tab_wt_d  [ENTRIES];
  logic [ENTRIES-1:0]     tab_val_q, tab_val_d;

  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [STATUS_W-1:0]    st_q, st_d;

  logic [ENTRIES-1:0]     hit, hit_oh, free_oh, swp;
  logic                   any_hit, any_free;

  logic [STATUS_W-1:0]    out_st_q;
  logic [TOKEN_BITS-1:0]  out_tok_q;
  logic [WEIGHT_BITS-1:0] out_wt_q;
  logic                   out_vld_q;

  logic [IDX_W-1:0]       sel;
  logic                   sel_ok;

  // Parallel match against every valid slot.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = tab_val_q[i] && (tab_tok_q[i] == tok_q);
    end
  end

  // Lowest matching slot and lowest free slot, isolated as one-hot vectors.
  assign hit_oh   = hit & (~hit + ENTRIES'(1));
  assign free_oh  = ~tab_val_q & (tab_val_q + ENTRIES'(1));
  assign any_hit  = |hit;
  assign any_free = !(&tab_val_q);

  // Swap decision for the neighbor pair picked by the pass counter.
  always_comb begin
    swp = '0;
    for (int i = 0; i < ENTRIES - 1; i++) begin
      swp[i] = (cnt_q == IDX_W'(i)) && (tab_wt_q[i+1] > tab_wt_q[i]);
    end
  end

  // Table update for an executed action or one step of the pass.
  always_comb begin
    tab_tok_d = tab_tok_q;
    tab_wt_d  = tab_wt_q;
    tab_val_d = tab_val_q;
    if (cmd_i.exec) begin
      case (act_q)
        ACT_ADD: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (any_hit) begin
              if (hit_oh[i] && (tab_wt_q[i] != '1)) begin
                tab_wt_d[i] = tab_wt_q[i] + WEIGHT_BITS'(1);
              end
            end else if (free_oh[i]) begin
              tab_tok_d[i] = tok_q;
              tab_wt_d[i]  = WEIGHT_BITS'(1);
              tab_val_d[i] = 1'b1;
            end
          end
        end
        ACT_WRITE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (int'(slot_q) == i) begin
              tab_tok_d[i] = tok_q;
              tab_wt_d[i]  = wgt_q;
              tab_val_d[i] = vld_q;
            end
          end
        end
        ACT_READ: begin
          tab_val_d = tab_val_q;
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++) begin
            tab_tok_d[i] = '0;
            tab_wt_d[i]  = '0;
          end
          tab_val_d = '0;
        end
      endcase
    end else if (cmd_i.swap_step) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (swp[i]) begin
          tab_tok_d[i]   = tab_tok_q[i+1];
          tab_wt_d[i]    = tab_wt_q[i+1];
          tab_val_d[i]   = tab_val_q[i+1];
          tab_tok_d[i+1] = tab_tok_q[i];
          tab_wt_d[i+1]  = tab_wt_q[i];
          tab_val_d[i+1] = tab_val_q[i];
        end
      end
    end
  end

  // Result status is decided when the action executes.
  always_comb begin
    st_d = st_q;
    if (cmd_i.exec) begin
      case (act_q)
        ACT_ADD: begin
          if (any_hit) begin
            st_d = STAT_RAISED;
          end else if (any_free) begin
            st_d = STAT_INSERTED;
          end else begin
            st_d = STAT_DROPPED;
          end
        end
        ACT_WRITE: st_d = STAT_WRITTEN;
        ACT_READ:  st_d = STAT_READ;
        default:   st_d = STAT_CLEARED;
      endcase
    end
  end

  // Pass counter walks the pairs from the front.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec) begin
      cnt_d = '0;
    end else if (cmd_i.swap_step) begin
      cnt_d = cnt_q + IDX_W'(1);
    end
  end

  assign stat_o.is_add    = (act_q == ACT_ADD);
  assign stat_o.swap_last = (cnt_q == IDX_W'(ENTRIES - 2));

  // Slot addressed by write and read.
  assign sel    = IDX_W'(slot_q);
  assign sel_ok = int'(slot_q) < ENTRIES;

  // Control and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_tok_q <= '{default: '0};
      tab_wt_q  <= '{default: '0};
      tab_val_q <= '0;
      cnt_q     <= '0;
      st_q      <= STAT_RAISED;
    end else begin
      tab_tok_q <= tab_tok_d;
      tab_wt_q  <= tab_wt_d;
      tab_val_q <= tab_val_d;
      cnt_q     <= cnt_d;
      st_q      <= st_d;
    end
  end

  // Input capture on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      tok_q  <= token_i;
      slot_q <= slot_i;
      wgt_q  <= entry_weight_i;
      vld_q  <= entry_valid_i;
    end
  end

  // Output register: slot zero after an add, the addressed slot after a write or read in range, zeros otherwise.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_st_q <= st_q;
      if (act_q == ACT_ADD) begin
        out_tok_q <= tab_tok_q[0];
        out_wt_q  <= tab_wt_q[0];
        out_vld_q <= tab_val_q[0];
      end else if ((act_q != ACT_CLEAR) && sel_ok) begin
        out_tok_q <= tab_tok_q[sel];
        out_wt_q  <= tab_wt_q[sel];
        out_vld_q <= tab_val_q[sel];
      end else begin
        out_tok_q <= '0;
        out_wt_q  <= '0;
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o     = out_st_q;
  assign out_token_o  = out_tok_q;
  assign out_weight_o = out_wt_q;
  assign out_valid_o  = out_vld_q;

endmodule

`default_nettype wire
